>>> rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int unsigned PAGE_COUNT_MAX = 32768;
  localparam int unsigned TOP_RANK       = 16;
  localparam int unsigned PAGE_BYTES     = 4096;

  localparam int unsigned IDX_W  = $clog2(PAGE_COUNT_MAX);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned OFF_W  = $clog2(PAGE_BYTES);
  localparam int unsigned RANK_W = 5;
  localparam int unsigned TAG_W  = 6;
  localparam int unsigned K_W    = $clog2(TOP_RANK);
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef logic [LINK_W-1:0] link_t;

  localparam link_t NO_LINK = link_t'(PAGE_COUNT_MAX);

  // Tag codes: free interior page, offset of free block heads, tail page.
  localparam logic [TAG_W-1:0] TAG_FREE  = TAG_W'(0);
  localparam logic [TAG_W-1:0] TAG_HEADS = TAG_W'(TOP_RANK);
  localparam logic [TAG_W-1:0] TAG_TAIL  = TAG_W'(2 * TOP_RANK + 1);

  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_ALLOC = 3'd1;
  localparam logic [2:0] REQ_FREE  = 3'd2;
  localparam logic [2:0] REQ_QUERY = 3'd3;
  localparam logic [2:0] REQ_COUNT = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [CFG_AW-3:0] REG_PAGE_COUNT = '0;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [RANK_W-1:0] rank;
    logic [ADDR_W-1:0] address;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  value;
  } bpa_rsp_t;

  // Pages in a block of rank r.
  function automatic link_t pages_of(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] s;
    s = r - RANK_W'(1);
    return link_t'(1) << s[K_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/bpa_ram.sv
`default_nettype none
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/bpa_cfg.sv
`default_nettype none
module bpa_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bpa_pkg::CFG_DW-1:0] pwdata,
  output logic      [bpa_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [bpa_pkg::CNT_W-1:0]  page_count_o
);
  import bpa_pkg::*;

  logic [CNT_W-1:0]    page_count_q, page_count_d;
  logic [CFG_AW-3:0]   reg_idx;
  logic                hit;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign hit     = (reg_idx == REG_PAGE_COUNT);
  assign pready  = 1'b1;

  always_comb begin
    page_count_d = page_count_q;
    if (psel && penable && pwrite && pready && hit) begin
      page_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= CNT_W'(PAGE_COUNT_MAX);
    end else begin
      page_count_q <= page_count_d;
    end
  end

  assign prdata       = hit ? CFG_DW'(page_count_q) : '0;
  assign page_count_o = page_count_q;

endmodule
`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// Channel   | Signals                                   | Item accepted when
// request   | start, busy, req_i                        | start high and busy low
// result    | result_valid_o, rsp_o                     | result_valid_o high (one cycle)
// config    | psel, penable, pwrite, paddr, pwdata, ... | psel, penable, pwrite, pready high
//
// Each request gives exactly one result, which the receiver cannot hold off; busy stays
// high from acceptance until the result.
// After reset a clearing pass writes every page tag, with busy high.
// Init runs the same pass, then carves the pool into blocks and pushes each onto its free list.
// Allocate unlinks the head of the smallest nonempty rank, pushes the upper half at each split
// rank and then writes the tags of the block's pages; free clears the block's tags, merges with
// each free buddy of the same rank and pushes the result; queries read tags rank by rank.
`default_nettype none
module buddy_page_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire bpa_pkg::bpa_req_t          req_i,
  output logic                            result_valid_o,
  output bpa_pkg::bpa_rsp_t               rsp_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bpa_pkg::CFG_DW-1:0] pwdata,
  output logic      [bpa_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import bpa_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLEAR   = 5'd1;
  localparam logic [4:0] S_DEC     = 5'd2;
  localparam logic [4:0] S_CARVE   = 5'd3;
  localparam logic [4:0] S_PUSH0   = 5'd4;
  localparam logic [4:0] S_PUSH1   = 5'd5;
  localparam logic [4:0] S_UNL0    = 5'd6;
  localparam logic [4:0] S_UNL1    = 5'd7;
  localparam logic [4:0] S_UNL2    = 5'd8;
  localparam logic [4:0] S_UNL3    = 5'd9;
  localparam logic [4:0] S_A_SPLIT = 5'd10;
  localparam logic [4:0] S_A_HEAD  = 5'd11;
  localparam logic [4:0] S_A_TAIL  = 5'd12;
  localparam logic [4:0] S_F_CHK   = 5'd13;
  localparam logic [4:0] S_F_CLR   = 5'd14;
  localparam logic [4:0] S_F_M0    = 5'd15;
  localparam logic [4:0] S_F_M1    = 5'd16;
  localparam logic [4:0] S_Q_CHK   = 5'd17;
  localparam logic [4:0] S_Q_RD    = 5'd18;
  localparam logic [4:0] S_Q_CMP   = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  localparam int unsigned LW2 = 2 * LINK_W;

  logic [CNT_W-1:0] page_count;

  bpa_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .page_count_o (page_count)
  );

  // Control state
  logic [4:0]        state_q, state_d, ret_q, ret_d;
  logic [ADDR_W-1:0] pool_base_q, pool_base_d;
  link_t             pool_pages_q, pool_pages_d;
  link_t             head_q [TOP_RANK];
  link_t             head_d [TOP_RANK];
  logic [CNT_W-1:0]  cnt_q [TOP_RANK];
  logic [CNT_W-1:0]  cnt_d [TOP_RANK];
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              init_clr_q, init_clr_d;
  logic              rv_q, rv_d;

  // Working registers
  bpa_req_t          req_q, req_d;
  bpa_rsp_t          rsp_q, rsp_d;
  link_t             rem_q, rem_d, off_q, off_d;
  logic [IDX_W-1:0]  idx_q, idx_d, op_idx_q, op_idx_d, sw_q, sw_d;
  logic [RANK_W-1:0] cur_r_q, cur_r_d, op_r_q, op_r_d;
  link_t             n_q, n_d, p_q, p_d;

  // Memory ports
  logic              tag_we, tag_re, link_we, link_re;
  logic [IDX_W-1:0]  tag_wa, tag_ra, link_wa, link_ra;
  logic [TAG_W-1:0]  tag_wd, tag_rd;
  logic [LW2-1:0]    link_wd, link_rd;

  bpa_ram #(.WIDTH(TAG_W), .DEPTH(PAGE_COUNT_MAX)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_wa),
    .wdata_i (tag_wd),
    .re_i    (tag_re),
    .raddr_i (tag_ra),
    .rdata_o (tag_rd)
  );

  bpa_ram #(.WIDTH(LW2), .DEPTH(PAGE_COUNT_MAX)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .re_i    (link_re),
    .raddr_i (link_ra),
    .rdata_o (link_rd)
  );

  // Address check of the held request.
  logic [ADDR_W-1:0] off_w;
  logic              page_ok;
  logic [IDX_W-1:0]  page_idx;

  assign off_w    = req_q.address - pool_base_q;
  assign page_ok  = (req_q.address != '0) && (req_q.address >= pool_base_q) &&
                    (off_w[OFF_W-1:0] == '0) &&
                    (off_w[ADDR_W-1:OFF_W] < (ADDR_W - OFF_W)'(pool_pages_q));
  assign page_idx = off_w[OFF_W +: IDX_W];

  // Smallest nonempty rank at or above the request.
  logic              rank_ok, found;
  logic [K_W-1:0]    fk;
  logic [RANK_W-1:0] fr, rank_m1, op_r_m1;
  logic [K_W-1:0]    rk, op_k;

  assign rank_ok = (req_q.rank != '0) && (req_q.rank <= RANK_W'(TOP_RANK));
  assign rank_m1 = req_q.rank - RANK_W'(1);
  assign rk      = rank_m1[K_W-1:0];
  assign op_r_m1 = op_r_q - RANK_W'(1);
  assign op_k    = op_r_m1[K_W-1:0];
  assign fr      = RANK_W'(fk) + RANK_W'(1);

  always_comb begin
    found = 1'b0;
    fk    = '0;
    for (int k = 0; k < TOP_RANK; k++) begin
      if (!found && (RANK_W'(k + 1) >= req_q.rank) && (cnt_q[k] != '0)) begin
        found = 1'b1;
        fk    = K_W'(k);
      end
    end
  end

  // Largest power of two within the remaining pool.
  logic [RANK_W-1:0] cm_rank;
  link_t             cm_pages;

  always_comb begin
    cm_rank = RANK_W'(1);
    for (int b = 0; b < LINK_W; b++) begin
      if (rem_q[b]) begin
        cm_rank = RANK_W'(b + 1);
      end
    end
  end

  assign cm_pages = pages_of(cm_rank);

  link_t             cur_pages, req_pages, bud_end, split_pages;
  logic [IDX_W-1:0]  bud, q_start, cur_mask;
  logic [ADDR_W-1:0] alloc_addr;
  link_t             h_w, n_w, p_w;

  assign cur_pages   = pages_of(cur_r_q);
  assign req_pages   = pages_of(req_q.rank);
  assign split_pages = pages_of(cur_r_q - RANK_W'(1));
  assign cur_mask    = cur_pages[IDX_W-1:0] - IDX_W'(1);
  assign bud         = idx_q ^ cur_pages[IDX_W-1:0];
  assign bud_end     = link_t'(bud) + cur_pages;
  assign q_start     = idx_q & ~cur_mask;
  assign alloc_addr  = pool_base_q + (ADDR_W'(idx_q) << OFF_W);
  assign h_w         = head_q[op_k];
  assign n_w         = link_rd[LW2-1:LINK_W];
  assign p_w         = link_rd[LINK_W-1:0];

  logic              fin;
  logic [1:0]        fin_st;
  logic [ADDR_W-1:0] fin_ba;
  logic [CNT_W-1:0]  fin_val;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    pool_base_d  = pool_base_q;
    pool_pages_d = pool_pages_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    init_clr_d   = init_clr_q;
    rv_d         = 1'b0;
    req_d        = req_q;
    rsp_d        = rsp_q;
    rem_d        = rem_q;
    off_d        = off_q;
    idx_d        = idx_q;
    op_idx_d     = op_idx_q;
    op_r_d       = op_r_q;
    sw_d         = sw_q;
    cur_r_d      = cur_r_q;
    n_d          = n_q;
    p_d          = p_q;
    tag_we       = 1'b0;
    tag_wa       = '0;
    tag_wd       = TAG_FREE;
    tag_re       = 1'b0;
    tag_ra       = '0;
    link_we      = 1'b0;
    link_wa      = '0;
    link_wd      = '0;
    link_re      = 1'b0;
    link_ra      = '0;
    fin          = 1'b0;
    fin_st       = ST_OK;
    fin_ba       = '0;
    fin_val      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_DEC;
        end
      end
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr_q;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = init_clr_q ? S_CARVE : S_IDLE;
        end
      end
      S_DEC: begin
        unique case (req_q.req_type)
          REQ_INIT: begin
            pool_base_d  = req_q.address;
            pool_pages_d = (page_count > CNT_W'(PAGE_COUNT_MAX)) ?
                           link_t'(PAGE_COUNT_MAX) : link_t'(page_count);
            rem_d        = pool_pages_d;
            off_d        = '0;
            for (int k = 0; k < TOP_RANK; k++) begin
              head_d[k] = NO_LINK;
              cnt_d[k]  = '0;
            end
            clr_d      = '0;
            init_clr_d = 1'b1;
            state_d    = S_CLEAR;
          end
          REQ_ALLOC: begin
            if (!rank_ok) begin
              fin    = 1'b1;
              fin_st = ST_INVALID;
            end else if (!found) begin
              fin    = 1'b1;
              fin_st = ST_NOSPACE;
            end else begin
              cur_r_d  = fr;
              idx_d    = head_q[fk][IDX_W-1:0];
              op_idx_d = head_q[fk][IDX_W-1:0];
              op_r_d   = fr;
              ret_d    = S_A_SPLIT;
              state_d  = S_UNL0;
            end
          end
          REQ_FREE, REQ_QUERY: begin
            if (page_ok) begin
              tag_re  = 1'b1;
              tag_ra  = page_idx;
              idx_d   = page_idx;
              state_d = (req_q.req_type == REQ_FREE) ? S_F_CHK : S_Q_CHK;
            end else begin
              fin    = 1'b1;
              fin_st = ST_INVALID;
            end
          end
          REQ_COUNT: begin
            fin = 1'b1;
            if (rank_ok) begin
              fin_val = cnt_q[rk];
            end else begin
              fin_st = ST_INVALID;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_INVALID;
          end
        endcase
      end
      S_CARVE: begin
        if (rem_q == '0) begin
          fin = 1'b1;
        end else begin
          op_idx_d = off_q[IDX_W-1:0];
          op_r_d   = cm_rank;
          off_d    = off_q + cm_pages;
          rem_d    = rem_q - cm_pages;
          ret_d    = S_CARVE;
          state_d  = S_PUSH0;
        end
      end
      S_PUSH0: begin
        tag_we          = 1'b1;
        tag_wa          = op_idx_q;
        tag_wd          = TAG_HEADS + TAG_W'(op_r_q);
        link_we         = 1'b1;
        link_wa         = op_idx_q;
        link_wd         = {h_w, NO_LINK};
        head_d[op_k]    = link_t'(op_idx_q);
        if (cnt_q[op_k] != '1) begin
          cnt_d[op_k] = cnt_q[op_k] + CNT_W'(1);
        end
        n_d = h_w;
        if (!h_w[IDX_W]) begin
          link_re = 1'b1;
          link_ra = h_w[IDX_W-1:0];
          state_d = S_PUSH1;
        end else begin
          state_d = ret_q;
        end
      end
      S_PUSH1: begin
        // The old head now points back at the block just pushed.
        link_we = 1'b1;
        link_wa = n_q[IDX_W-1:0];
        link_wd = {n_w, link_t'(op_idx_q)};
        state_d = ret_q;
      end
      S_UNL0: begin
        link_re = 1'b1;
        link_ra = op_idx_q;
        tag_we  = 1'b1;
        tag_wa  = op_idx_q;
        if (cnt_q[op_k] != '0) begin
          cnt_d[op_k] = cnt_q[op_k] - CNT_W'(1);
        end
        state_d = S_UNL1;
      end
      S_UNL1: begin
        n_d = n_w;
        p_d = p_w;
        if (p_w[IDX_W]) begin
          head_d[op_k] = n_w;
        end
        if (!p_w[IDX_W]) begin
          link_re = 1'b1;
          link_ra = p_w[IDX_W-1:0];
          state_d = S_UNL2;
        end else if (!n_w[IDX_W]) begin
          link_re = 1'b1;
          link_ra = n_w[IDX_W-1:0];
          state_d = S_UNL3;
        end else begin
          state_d = ret_q;
        end
      end
      S_UNL2: begin
        link_we = 1'b1;
        link_wa = p_q[IDX_W-1:0];
        link_wd = {n_q, p_w};
        if (!n_q[IDX_W]) begin
          link_re = 1'b1;
          link_ra = n_q[IDX_W-1:0];
          state_d = S_UNL3;
        end else begin
          state_d = ret_q;
        end
      end
      S_UNL3: begin
        link_we = 1'b1;
        link_wa = n_q[IDX_W-1:0];
        link_wd = {n_w, p_q};
        state_d = ret_q;
      end
      S_A_SPLIT: begin
        if (cur_r_q > req_q.rank) begin
          cur_r_d  = cur_r_q - RANK_W'(1);
          op_r_d   = cur_r_q - RANK_W'(1);
          op_idx_d = idx_q + split_pages[IDX_W-1:0];
          ret_d    = S_A_SPLIT;
          state_d  = S_PUSH0;
        end else begin
          state_d = S_A_HEAD;
        end
      end
      S_A_HEAD: begin
        tag_we = 1'b1;
        tag_wa = idx_q;
        tag_wd = TAG_W'(req_q.rank);
        sw_d   = IDX_W'(1);
        if (req_pages == link_t'(1)) begin
          fin    = 1'b1;
          fin_ba = alloc_addr;
        end else begin
          state_d = S_A_TAIL;
        end
      end
      S_A_TAIL: begin
        tag_we = 1'b1;
        tag_wa = idx_q + sw_q;
        tag_wd = TAG_TAIL;
        sw_d   = sw_q + IDX_W'(1);
        if (link_t'(sw_q) == req_pages - link_t'(1)) begin
          fin    = 1'b1;
          fin_ba = alloc_addr;
        end
      end
      S_F_CHK: begin
        if ((tag_rd >= TAG_W'(1)) && (tag_rd <= TAG_HEADS)) begin
          cur_r_d = tag_rd[RANK_W-1:0];
          sw_d    = '0;
          state_d = S_F_CLR;
        end else begin
          fin    = 1'b1;
          fin_st = ST_INVALID;
        end
      end
      S_F_CLR: begin
        tag_we = 1'b1;
        tag_wa = idx_q + sw_q;
        sw_d   = sw_q + IDX_W'(1);
        if (link_t'(sw_q) == cur_pages - link_t'(1)) begin
          state_d = S_F_M0;
        end
      end
      S_F_M0: begin
        if ((cur_r_q < RANK_W'(TOP_RANK)) && (bud_end <= pool_pages_q)) begin
          tag_re  = 1'b1;
          tag_ra  = bud;
          state_d = S_F_M1;
        end else begin
          op_idx_d = idx_q;
          op_r_d   = cur_r_q;
          ret_d    = S_FIN;
          state_d  = S_PUSH0;
        end
      end
      S_F_M1: begin
        // Merge only with a buddy that heads a free block of the same rank.
        if (tag_rd == TAG_HEADS + TAG_W'(cur_r_q)) begin
          op_idx_d = bud;
          op_r_d   = cur_r_q;
          idx_d    = idx_q & ~cur_pages[IDX_W-1:0];
          cur_r_d  = cur_r_q + RANK_W'(1);
          ret_d    = S_F_M0;
          state_d  = S_UNL0;
        end else begin
          op_idx_d = idx_q;
          op_r_d   = cur_r_q;
          ret_d    = S_FIN;
          state_d  = S_PUSH0;
        end
      end
      S_Q_CHK: begin
        if ((tag_rd >= TAG_W'(1)) && (tag_rd <= TAG_HEADS)) begin
          fin     = 1'b1;
          fin_val = CNT_W'(tag_rd);
        end else if (tag_rd == TAG_TAIL) begin
          fin    = 1'b1;
          fin_st = ST_INVALID;
        end else begin
          cur_r_d = RANK_W'(1);
          state_d = S_Q_RD;
        end
      end
      S_Q_RD: begin
        tag_re  = 1'b1;
        tag_ra  = q_start;
        state_d = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (tag_rd == TAG_HEADS + TAG_W'(cur_r_q)) begin
          fin     = 1'b1;
          fin_val = CNT_W'(cur_r_q);
        end else if (cur_r_q == RANK_W'(TOP_RANK)) begin
          fin    = 1'b1;
          fin_st = ST_INVALID;
        end else begin
          cur_r_d = cur_r_q + RANK_W'(1);
          state_d = S_Q_RD;
        end
      end
      S_FIN: begin
        fin = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      rsp_d.status        = fin_st;
      rsp_d.block_address = fin_ba;
      rsp_d.value         = fin_val;
      rv_d                = 1'b1;
      state_d             = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      ret_q        <= S_IDLE;
      pool_base_q  <= '0;
      pool_pages_q <= '0;
      clr_q        <= '0;
      init_clr_q   <= 1'b0;
      rv_q         <= 1'b0;
      for (int k = 0; k < TOP_RANK; k++) begin
        head_q[k] <= NO_LINK;
        cnt_q[k]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      pool_base_q  <= pool_base_d;
      pool_pages_q <= pool_pages_d;
      clr_q        <= clr_d;
      init_clr_q   <= init_clr_d;
      rv_q         <= rv_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rsp_q    <= rsp_d;
    rem_q    <= rem_d;
    off_q    <= off_d;
    idx_q    <= idx_d;
    op_idx_q <= op_idx_d;
    op_r_q   <= op_r_d;
    sw_q     <= sw_d;
    cur_r_q  <= cur_r_d;
    n_q      <= n_d;
    p_q      <= p_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign rsp_o          = rsp_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_INVALID ||
                        rsp_o.status == ST_NOSPACE))
    else $error("undefined status code");

endmodule
`default_nettype wire
